FILE: rtl/max_cut_exhaustive_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max cut search block
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MAX_CUT_EXHAUSTIVE_DEFINES_SVH
`define MAX_CUT_EXHAUSTIVE_DEFINES_SVH

// Same-cycle implication
`define MCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mce_pkg.sv
// ----------------------------------------------------------------------------
// mce_pkg
// Sizes, codes and controller/datapath interface types for the max cut search.
// ----------------------------------------------------------------------------
package mce_pkg;

  localparam int MAX_NODES   = 16;
  localparam int STORE_DEPTH = MAX_NODES * MAX_NODES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LIDX_W      = $clog2(STORE_DEPTH + 1);
  localparam int NODE_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SPLIT_W     = (MAX_NODES > 1) ? MAX_NODES - 1 : 1;
  localparam int CNT_W       = 5;
  localparam int WEIGHT_W    = 16;
  localparam int RESULT_W    = 24;
  localparam int SUM_W       = WEIGHT_W + ADDR_W;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [RESULT_W-1:0] VALUE_MAX      = '1;
  localparam logic [CNT_W-1:0]    NODE_COUNT_RST = CNT_W'(MAX_NODES);

  // Register index as decoded from the word address bit
  localparam logic REG_NODE_COUNT = 1'b0;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // store one weight transfer
    logic start;    // last entry seen: clear search state
    logic step;     // issue one weight read of the search
    logic publish;  // move best value into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic single_node;  // one node in use: nothing to search
    logic issue_last;   // final pair of final split is being issued
    logic busy;         // read/accumulate pipeline holds work
    logic out_busy;     // output register full and not taken this cycle
  } stat_t;

endpackage

FILE: rtl/mce_datapath.sv
// ----------------------------------------------------------------------------
// mce_datapath
// Weight memory, load pointer, split/pair counters, accumulate pipeline and
// output register of the max cut search.
// ----------------------------------------------------------------------------
module mce_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mce_pkg::cmd_t                 cmd_i,
  input  logic [mce_pkg::CNT_W-1:0]     n_i,
  input  logic [mce_pkg::WEIGHT_W-1:0]  weight_i,
  input  logic                          out_ready_i,
  output mce_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  output logic [mce_pkg::RESULT_W-1:0]  best_cut_o
);

  logic [mce_pkg::WEIGHT_W-1:0] mem [mce_pkg::STORE_DEPTH];
  logic [mce_pkg::WEIGHT_W-1:0] rdata_r;

  logic [mce_pkg::LIDX_W-1:0]   lidx_r, lidx_nxt;
  logic [mce_pkg::LIDX_W-1:0]   n_wide;
  logic [mce_pkg::LIDX_W-1:0]   total;
  logic                         wr_en;

  logic [mce_pkg::NODE_W-1:0]   a_r, a_nxt;
  logic [mce_pkg::NODE_W-1:0]   b_r, b_nxt;
  logic [mce_pkg::SPLIT_W-1:0]  m_r, m_nxt;
  logic [mce_pkg::CNT_W-1:0]    n_m1;
  logic [mce_pkg::NODE_W-1:0]   node_last;
  logic [mce_pkg::SPLIT_W-1:0]  split_mask;
  logic [mce_pkg::MAX_NODES-1:0] side_b;
  logic [mce_pkg::ADDR_W-1:0]   rd_addr;
  logic                         pair_first, pair_last, pair_add;

  logic                         s1_v_r, s1_add_r, s1_first_r, s1_last_r;
  logic [mce_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [mce_pkg::SUM_W-1:0]    contrib;
  logic                         s2_v_r;
  logic [mce_pkg::SUM_W-1:0]    final_r;
  logic [mce_pkg::RESULT_W-1:0] sat;
  logic [mce_pkg::RESULT_W-1:0] best_r;

  logic                         out_valid_r;
  logic [mce_pkg::RESULT_W-1:0] best_cut_r;

  // Load pointer: store while there is room, rewind on the last entry
  assign n_wide = mce_pkg::LIDX_W'(n_i);
  assign total  = n_wide * n_wide;
  assign wr_en  = cmd_i.load && (lidx_r < total);

  always_comb begin
    lidx_nxt = lidx_r;
    if (cmd_i.start) begin
      lidx_nxt = '0;
    end else if (wr_en) begin
      lidx_nxt = lidx_r + mce_pkg::LIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lidx_r <= '0;
    end else begin
      lidx_r <= lidx_nxt;
    end
  end

  // Weight memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[lidx_r[mce_pkg::ADDR_W-1:0]] <= weight_i;
    end
    rdata_r <= mem[rd_addr];
  end

  // Pair and split decode
  assign n_m1      = n_i - mce_pkg::CNT_W'(1);
  assign node_last = n_m1[mce_pkg::NODE_W-1:0];
  assign side_b    = {m_r, 1'b0};

  always_comb begin
    for (int i = 0; i < mce_pkg::SPLIT_W; i++) begin
      split_mask[i] = (mce_pkg::CNT_W'(i + 1) < n_i);
    end
  end

  assign rd_addr    = mce_pkg::ADDR_W'(a_r) * mce_pkg::ADDR_W'(n_i) + mce_pkg::ADDR_W'(b_r);
  assign pair_first = (a_r == '0) && (b_r == mce_pkg::NODE_W'(1));
  assign pair_last  = (a_r == node_last) && (b_r == node_last);
  assign pair_add   = side_b[b_r] && !side_b[a_r];

  // Advance a fastest, then b, then the split
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    m_nxt = m_r;
    if (cmd_i.start) begin
      a_nxt = '0;
      b_nxt = mce_pkg::NODE_W'(1);
      m_nxt = '0;
    end else if (cmd_i.step) begin
      if (a_r == node_last) begin
        a_nxt = '0;
        if (b_r == node_last) begin
          b_nxt = mce_pkg::NODE_W'(1);
          m_nxt = m_r + mce_pkg::SPLIT_W'(1);
        end else begin
          b_nxt = b_r + mce_pkg::NODE_W'(1);
        end
      end else begin
        a_nxt = a_r + mce_pkg::NODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= mce_pkg::NODE_W'(1);
      m_r <= '0;
    end else begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      m_r <= m_nxt;
    end
  end

  // Stage 1 flags travel beside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd_i.step;
    end
    s1_add_r   <= pair_add;
    s1_first_r <= pair_first;
    s1_last_r  <= pair_last;
  end

  // Stage 2: accumulate the split's cut value
  assign contrib = s1_add_r ? mce_pkg::SUM_W'(rdata_r) : '0;
  assign sum_nxt = (s1_first_r ? '0 : sum_r) + contrib;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_last_r;
    end
    if (s1_v_r) begin
      sum_r <= sum_nxt;
    end
    if (s1_v_r && s1_last_r) begin
      final_r <= sum_nxt;
    end
  end

  // Stage 3: saturate and keep the maximum
  assign sat = (final_r > mce_pkg::SUM_W'(mce_pkg::VALUE_MAX)) ? mce_pkg::VALUE_MAX
                                                                : final_r[mce_pkg::RESULT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (cmd_i.start) begin
      best_r <= '0;
    end else if (s2_v_r && (sat > best_r)) begin
      best_r <= sat;
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
    if (cmd_i.publish) begin
      best_cut_r <= best_r;
    end
  end

  assign out_valid_o = out_valid_r;
  assign best_cut_o  = best_cut_r;

  assign stat_o.single_node = (n_i == mce_pkg::CNT_W'(1));
  assign stat_o.issue_last  = pair_last && (m_r == split_mask);
  assign stat_o.busy        = s1_v_r || s2_v_r;
  assign stat_o.out_busy    = out_valid_r && !out_ready_i;

endmodule

FILE: rtl/mce_ctrl.sv
// ----------------------------------------------------------------------------
// mce_ctrl
// Sequencer for load, search, drain and result hand-off.
// ----------------------------------------------------------------------------
module mce_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  input  mce_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output mce_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready_o = (state_r == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd_o.load    = 1'b0;
    cmd_o.start   = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.publish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd_o.load  = accept;
        cmd_o.start = accept && in_last_i;
        if (accept && in_last_i) begin
          state_nxt = stat_i.single_node ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.step = 1'b1;
        if (stat_i.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat_i.busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/max_cut_exhaustive.sv
// ----------------------------------------------------------------------------
// max_cut_exhaustive
// Exhaustive max cut search over a directed weight matrix of up to 16 nodes.
// ----------------------------------------------------------------------------
// Usage:
//   Write node_count (N) on the cfg APB port at address 0 while idle.
//   Stream the N*N weights row-major on in_* (tdata = weight), one transfer
//   per cycle; entries past N*N are dropped. The transfer with in_tlast set
//   stores its weight and starts the search, and in_tready drops.
//   The search walks every split of nodes 1..N-1 (node 0 stays on side A),
//   reading one weight from the single memory read port per cycle; it
//   reads N*(N-1) weights for each of the 2^(N-1) splits, then drains the pipeline;
//   N = 1 finishes at once with 0. That read port sets the search rate.
//   The best cut value then lands in the output register (out_tdata) and
//   in_tready returns; loading of the next matrix may proceed while the
//   result waits. If out_tready is held low, the result holds, and a
//   following search finishes but waits to publish until it is taken.
//   Reset (synchronous, active low) sets node_count to 16, empties the
//   pipeline and output; weight memory contents are not cleared.
// ----------------------------------------------------------------------------
`include "max_cut_exhaustive_defines.svh"

module max_cut_exhaustive (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,    // [15:0] weight
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,   // [23:0] best_cut
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mce_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [mce_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [mce_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  logic [mce_pkg::CNT_W-1:0] node_count_r;
  logic [mce_pkg::CNT_W-1:0] n_eff;
  logic                      cfg_write;
  mce_pkg::cmd_t             cmd;
  mce_pkg::stat_t            stat;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= mce_pkg::NODE_COUNT_RST;
    end else if (cfg_write && (cfg_paddr[2] == mce_pkg::REG_NODE_COUNT)) begin
      node_count_r <= cfg_pwdata[mce_pkg::CNT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == mce_pkg::REG_NODE_COUNT)
                      ? mce_pkg::CFG_DATA_W'(node_count_r) : '0;

  // Clamp node count into the supported range
  always_comb begin
    priority if (node_count_r == '0) begin
      n_eff = mce_pkg::CNT_W'(1);
    end else if (node_count_r > mce_pkg::CNT_W'(mce_pkg::MAX_NODES)) begin
      n_eff = mce_pkg::CNT_W'(mce_pkg::MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  mce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_last_i  (in_tlast),
    .stat_i     (stat),
    .in_ready_o (in_tready),
    .cmd_o      (cmd)
  );

  mce_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .n_i         (n_eff),
    .weight_i    (in_tdata),
    .out_ready_i (out_tready),
    .stat_o      (stat),
    .out_valid_o (out_tvalid),
    .best_cut_o  (out_tdata)
  );

  // Checks
  `MCE_ASSERT_NEXT(a_busy_after_last, in_tvalid && in_tready && in_tlast, !in_tready, "input ready right after last transfer")
  `MCE_ASSERT_NOW(a_idle_pipe_empty, in_tready, !stat.busy, "search pipeline active while input ready")
  `MCE_ASSERT_NOW(a_publish_drained, $rose(out_tvalid), !stat.busy, "result published before pipeline drained")

endmodule
